// ===== hdl/sbs_pkg.sv =====
// Package for the subpixel bilinear shift block: widths, register codes,
// window struct, the phase clamp and the last-column helper. No dependencies.
package sbs_pkg;

  localparam int PHASES_X   = 8;
  localparam int PHASES_Y   = 8;
  localparam int MAX_WIDTH  = 64;

  localparam int PIX_W      = 8;
  localparam int SHIFT_W    = 3;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int PHASES_MAX = (PHASES_X > PHASES_Y) ? PHASES_X : PHASES_Y;
  localparam int PH_W       = $clog2(PHASES_MAX + 1);
  localparam int AREA       = PHASES_X * PHASES_Y;
  localparam int WT_W       = $clog2(AREA + 1);
  localparam int SUM_W      = PIX_W + WT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd2;

  // Four neighbors of the current raster position, already zeroed at the edges.
  typedef struct packed {
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] above_left;
  } window_t;

  function automatic logic [PH_W-1:0] clamp_phase(input logic [SHIFT_W-1:0] s,
                                                  input int phases);
    if (int'(s) >= phases) begin
      return PH_W'(phases - 1);
    end
    return PH_W'(s);
  endfunction

  // Last valid column index for a raw width register value.
  function automatic logic [ADDR_W-1:0] last_index(input logic [CFG_DATA_W-1:0] w);
    if (w == '0) begin
      return '0;
    end
    if (int'(w) > MAX_WIDTH) begin
      return ADDR_W'(MAX_WIDTH - 1);
    end
    return ADDR_W'(int'(w) - 1);
  endfunction

endpackage

// ===== hdl/sbs_if.sv =====
// Channel interfaces of the subpixel bilinear shift block.
// Depends on sbs_pkg for field widths.
interface sbs_pixel_in_if import sbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface sbs_pixel_out_if import sbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             end_of_image;

  modport source (output valid, output pixel_out, output end_of_image, input ready);
  modport sink   (input valid, input pixel_out, input end_of_image, output ready);
endinterface

interface sbs_cfg_if import sbs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/sbs_line_buffer.sv =====
// Line buffer holding the previous image row, one word per column.
// Depends on sbs_pkg.
module sbs_line_buffer import sbs_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Forward the word being written when the read in the same cycle hits the same column.
  always_ff @(posedge clk) begin
    if (wr_en && (rd_addr == wr_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sbs_scan_ctrl.sv =====
// Raster counters and neighbor window for the subpixel bilinear shift.
// Depends on sbs_pkg; drives the line buffer addresses.
module sbs_scan_ctrl import sbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              accept,
  input  logic [ADDR_W-1:0] last_col,
  input  logic [PIX_W-1:0]  pixel,
  input  logic [PIX_W-1:0]  above_raw,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [ADDR_W-1:0] rd_addr,
  output window_t           win,
  output logic              eoi
);

  logic [ADDR_W-1:0] column_count;
  logic [ADDR_W-1:0] row_count;
  logic [ADDR_W-1:0] column_count_next;
  logic [ADDR_W-1:0] row_count_next;
  logic [PIX_W-1:0]  left_pixel;
  logic [PIX_W-1:0]  above_left_pixel;
  logic              col_last;
  logic              row_last;

  assign col_last = (column_count == last_col);
  assign row_last = (row_count == last_col);
  assign eoi      = col_last && row_last;

  always_comb begin
    if (col_last) begin
      column_count_next = '0;
      row_count_next    = row_last ? '0 : row_count + 1'b1;
    end else begin
      column_count_next = column_count + 1'b1;
      row_count_next    = row_count;
    end
  end

  // Prefetch the next column from the line buffer as soon as a word is taken.
  assign wr_addr = column_count;
  assign rd_addr = accept ? column_count_next : column_count;

  assign win.cur        = pixel;
  assign win.left       = (column_count != '0) ? left_pixel : '0;
  assign win.above      = (row_count != '0) ? above_raw : '0;
  assign win.above_left = ((row_count != '0) && (column_count != '0)) ?
                          above_left_pixel : '0;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count     <= '0;
      row_count        <= '0;
      left_pixel       <= '0;
      above_left_pixel <= '0;
    end else if (accept) begin
      column_count     <= column_count_next;
      row_count        <= row_count_next;
      left_pixel       <= pixel;
      above_left_pixel <= above_raw;
    end
  end

endmodule

// ===== hdl/sbs_mix.sv =====
// Bilinear weight registers and the weighted sum of the neighbor window.
// Depends on sbs_pkg.
module sbs_mix import sbs_pkg::*; (
  input  logic               clk,
  input  logic [SHIFT_W-1:0] shift_x,
  input  logic [SHIFT_W-1:0] shift_y,
  input  window_t            win,
  output logic [PIX_W-1:0]   pixel
);

  logic [PH_W-1:0]  sx;
  logic [PH_W-1:0]  sy;
  logic [PH_W-1:0]  ix;
  logic [PH_W-1:0]  iy;
  logic [WT_W-1:0]  wt_cur;
  logic [WT_W-1:0]  wt_left;
  logic [WT_W-1:0]  wt_above;
  logic [WT_W-1:0]  wt_above_left;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] quot;

  assign sx = clamp_phase(shift_x, PHASES_X);
  assign sy = clamp_phase(shift_y, PHASES_Y);
  assign ix = PH_W'(PHASES_X) - sx;
  assign iy = PH_W'(PHASES_Y) - sy;

  // Weights follow the phase registers; the user must change those only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    wt_cur        <= WT_W'(iy) * WT_W'(ix);
    wt_left       <= WT_W'(iy) * WT_W'(sx);
    wt_above      <= WT_W'(sy) * WT_W'(ix);
    wt_above_left <= WT_W'(sy) * WT_W'(sx);
  end

  assign sum = SUM_W'(wt_cur) * SUM_W'(win.cur)
             + SUM_W'(wt_left) * SUM_W'(win.left)
             + SUM_W'(wt_above) * SUM_W'(win.above)
             + SUM_W'(wt_above_left) * SUM_W'(win.above_left);

  assign quot  = sum / SUM_W'(AREA);
  assign pixel = (quot > SUM_W'(255)) ? 8'hFF : quot[PIX_W-1:0];

endmodule

// ===== hdl/subpixel_bilinear_shift.sv =====
// Top level of the subpixel bilinear shift block.
// Depends on sbs_pkg, the channel interfaces, sbs_line_buffer, sbs_scan_ctrl, sbs_mix.
//
// Usage:
//   in_ch carries one 8-bit pixel per word in raster order over a square image;
//   out_ch returns one shifted pixel per input word, at the same raster
//   position, with end_of_image high on the last pixel of each image.
//   cfg writes shift_x (index 0), shift_y (index 1) and image_width (index 2);
//   it is always ready. Writing image_width restarts at the top-left corner.
//   Write configuration only while no pixel is in flight.
// Timing:
//   A word taken at an edge is loaded into the output register and shows on
//   out_ch after that edge. Throughput is one pixel per cycle while out_ch is ready,
//   set by the single line buffer port pair (one write, one prefetch read per pixel).
//   After reset and after any configuration write, in_ch.ready is held low
//   while the weight registers and the line buffer prefetch settle.
// Stall:
//   The output register holds its word while out_ch.ready is low; input is
//   still taken in the cycle the held word leaves.
// Reset: rst is synchronous, active high; it clears counters, neighbors,
//   registers (shift 0, width 1) and the output valid.
module subpixel_bilinear_shift import sbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  sbs_pixel_in_if.sink    in_ch,
  sbs_pixel_out_if.source out_ch,
  sbs_cfg_if.sink         cfg
);

  logic [SHIFT_W-1:0]    shift_x;
  logic [SHIFT_W-1:0]    shift_y;
  logic [CFG_DATA_W-1:0] image_width;
  logic                  primed;
  logic                  out_valid;
  logic [PIX_W-1:0]      pixel_out;
  logic                  end_of_image;

  logic                  cfg_write;
  logic                  restart;
  logic                  accept;
  logic [ADDR_W-1:0]     last_col;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [PIX_W-1:0]      above_raw;
  logic [PIX_W-1:0]      mix_pixel;
  logic                  eoi;
  window_t               win;

  // Configuration port.
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;
  assign restart   = cfg_write && (cfg.index == CFG_IMAGE_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_x     <= '0;
      shift_y     <= '0;
      image_width <= CFG_DATA_W'(1);
    end else if (cfg_write) begin
      case (cfg.index)
        CFG_SHIFT_X:     shift_x     <= cfg.data[SHIFT_W-1:0];
        CFG_SHIFT_Y:     shift_y     <= cfg.data[SHIFT_W-1:0];
        CFG_IMAGE_WIDTH: image_width <= cfg.data;
        default:         ;
      endcase
    end
  end

  // Hold off input after reset or a configuration write so the weights and
  // the prefetched line buffer word are current.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      primed <= 1'b0;
    end else begin
      primed <= 1'b1;
    end
  end

  assign last_col    = last_index(image_width);
  assign in_ch.ready = primed && (!out_valid || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  sbs_scan_ctrl u_scan (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .accept    (accept),
    .last_col  (last_col),
    .pixel     (in_ch.pixel_in),
    .above_raw (above_raw),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .win       (win),
    .eoi       (eoi)
  );

  sbs_line_buffer u_line (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wr_addr),
    .wr_data (in_ch.pixel_in),
    .rd_addr (rd_addr),
    .rd_data (above_raw)
  );

  sbs_mix u_mix (
    .clk     (clk),
    .shift_x (shift_x),
    .shift_y (shift_y),
    .win     (win),
    .pixel   (mix_pixel)
  );

  // Output register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_out    <= mix_pixel;
      end_of_image <= eoi;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.pixel_out    = pixel_out;
  assign out_ch.end_of_image = end_of_image;

endmodule

// ===== tb/sbs_shift_check_pkg.sv =====
// Scoreboard for the subpixel bilinear shift testbench: a cycle-free predictor
// of the shifted pixel stream and the queue of words still owed by the block.
// Depends on sbs_pkg for widths, phase counts and register indexes.
package sbs_shift_check_pkg;
  import sbs_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             eoi;
  } shifted_word_t;

  class shift_checker;
    logic [SHIFT_W-1:0]    sx_reg;
    logic [SHIFT_W-1:0]    sy_reg;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [PIX_W-1:0]      line_mem [MAX_WIDTH];
    logic [PIX_W-1:0]      left_pix;
    logic [PIX_W-1:0]      diag_pix;
    int unsigned           col_pos;
    int unsigned           row_pos;
    shifted_word_t         expected_q[$];
    int                    errors;

    function new();
      sx_reg    = '0;
      sy_reg    = '0;
      width_reg = CFG_DATA_W'(1);
      foreach (line_mem[i]) line_mem[i] = '0;
      left_pix  = '0;
      diag_pix  = '0;
      col_pos   = 0;
      row_pos   = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SHIFT_X: sx_reg = data[SHIFT_W-1:0];
        CFG_SHIFT_Y: sy_reg = data[SHIFT_W-1:0];
        CFG_IMAGE_WIDTH: begin
          // a new width always starts a new image at the top-left
          width_reg = data;
          col_pos   = 0;
          row_pos   = 0;
          left_pix  = '0;
          diag_pix  = '0;
        end
        default: ;
      endcase
    endfunction

    // Work out the word owed for one accepted input pixel and advance the scan.
    function void note_pixel(logic [PIX_W-1:0] cur);
      int unsigned w, sx, sy, ix, iy, col, row, lf, ab, al, acc;
      shifted_word_t word;
      w  = (width_reg == 0) ? 1 : ((int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      sx = (sx_reg >= PHASES_X) ? PHASES_X - 1 : sx_reg;
      sy = (sy_reg >= PHASES_Y) ? PHASES_Y - 1 : sy_reg;
      ix = PHASES_X - sx;
      iy = PHASES_Y - sy;
      col = (col_pos >= w) ? w - 1 : col_pos;
      row = (row_pos >= w) ? w - 1 : row_pos;
      lf = (col > 0) ? left_pix : 0;
      ab = (row > 0) ? line_mem[col] : 0;
      al = (row > 0 && col > 0) ? diag_pix : 0;
      acc = (iy * ix * cur + iy * sx * lf + sy * ix * ab + sy * sx * al) / (PHASES_X * PHASES_Y);
      if (acc > 255) acc = 255;
      diag_pix      = line_mem[col];
      line_mem[col] = cur;
      left_pix      = cur;
      word.pixel = PIX_W'(acc);
      word.eoi   = (col == w - 1 && row == w - 1);
      if (col == w - 1) begin
        col_pos = 0;
        row_pos = (row == w - 1) ? 0 : row + 1;
      end else begin
        col_pos = col + 1;
        row_pos = row;
      end
      expected_q.push_back(word);
    endfunction

    function void check_pixel(logic [PIX_W-1:0] pix, logic eoi);
      shifted_word_t want;
      if (expected_q.size() == 0) begin
        $error("output word with nothing owed: pixel_out=%0d end_of_image=%0b", pix, eoi);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (pix !== want.pixel) begin
        $error("pixel_out: expected %0d, got %0d", want.pixel, pix);
        errors++;
      end
      if (eoi !== want.eoi) begin
        $error("end_of_image: expected %0b, got %0b", want.eoi, eoi);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench for subpixel_bilinear_shift: drives pixel, result and
// register channels and checks every output word against shift_checker.
// Depends on sbs_pkg, the sbs channel interfaces and sbs_shift_check_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbs_pkg::*;
  import sbs_shift_check_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;       // long back-pressure stretch on the result side
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int TAIL_CYCLES  = 8;         // extra wait after the drain for stray words

  // index 3 has no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef logic [PIX_W-1:0] pixel_q_t[$];
  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst;

  sbs_pixel_in_if  in_ch();
  sbs_pixel_out_if out_ch();
  sbs_cfg_if       cfg();

  subpixel_bilinear_shift uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  shift_checker pixel_book = new();

  bit src_gaps_on = 1'b1;   // cleared for phases that send back-to-back words
  bit hold_req    = 1'b0;   // ask the result side for one long hold-off

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: alternate ready runs and stalls, one level per cycle so that
  // ready never gets two updates in one time step. A pending hold request
  // wins at once and holds ready low for HOLD_CYCLES, counted here.
  initial begin : result_sink
    bit          level;
    int unsigned left_cycles;
    level       = 1'b1;
    left_cycles = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req    = 1'b0;
        level       = 1'b0;
        left_cycles = HOLD_CYCLES;
      end else if (left_cycles == 0) begin
        if (level) begin
          level       = 1'b0;
          left_cycles = 1 + gap_len();
        end else begin
          // now and then a long run of ready with no stalls at all
          level       = 1'b1;
          left_cycles = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 12);
        end
      end
      left_cycles--;
      out_ch.ready <= level;
    end
  end

  // Check every word taken from the result channel. Values read here are the
  // ones present at the edge, since all drivers update through NBAs.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      pixel_book.check_pixel(out_ch.pixel_out, out_ch.end_of_image);
    end
  end

  // Offer the pixels in order, note each one as it is taken, and drop valid
  // only for a gap or after the last word.
  task automatic stream(input pixel_q_t pix);
    int unsigned gap;
    foreach (pix[i]) begin
      in_ch.valid    <= 1'b1;
      in_ch.pixel_in <= pix[i];
      do @(posedge clk); while (!in_ch.ready);
      pixel_book.note_pixel(pix[i]);
      gap = src_gaps_on ? gap_len() : 0;
      if (gap > 0 || i == pix.size() - 1) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold until every owed word has come back.
  task automatic wait_idle();
    while (pixel_book.pending() != 0) @(posedge clk);
  endtask

  // Write a list of registers back to back; call only while idle.
  task automatic apply_regs(input reg_write_t regs[$]);
    foreach (regs[i]) begin
      cfg.valid <= 1'b1;
      cfg.index <= regs[i].idx;
      cfg.data  <= regs[i].data;
      do @(posedge clk); while (!cfg.ready);
      pixel_book.write_reg(regs[i].idx, regs[i].data);
    end
    cfg.valid <= 1'b0;
  endtask

  initial begin : stimulus
    pixel_q_t              pix;
    reg_write_t            regs[$];
    logic [CFG_DATA_W-1:0] wr;
    int unsigned           sent, n, area, w_eff, r;
    int                    phase;

    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.pixel_in <= '0;
    cfg.valid      <= 1'b0;
    cfg.index      <= CFG_SHIFT_X;
    cfg.data       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings give 1x1 images: every word ends an image.
    pix = {8'd0, 8'd255};
    stream(pix);

    // Largest phases, upper data bits set so they must be masked off;
    // a full 3x3 image of white must come out white at the far corner.
    wait_idle();
    regs = {reg_write_t'{CFG_SHIFT_X, 7'h7F}, reg_write_t'{CFG_SHIFT_Y, 7'h3F},
            reg_write_t'{CFG_IMAGE_WIDTH, 7'd3}};
    apply_regs(regs);
    pix = {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    stream(pix);

    // Width zero acts as width one; the spare index is ignored.
    wait_idle();
    regs = {reg_write_t'{CFG_IMAGE_WIDTH, 7'd0}, reg_write_t'{CFG_SPARE, 7'h55},
            reg_write_t'{CFG_SHIFT_X, 7'd3}, reg_write_t'{CFG_SHIFT_Y, 7'd5}};
    apply_regs(regs);
    pix = {8'd128, 8'd255};
    stream(pix);

    // Shift changed mid-image: the new phase applies from the next word on.
    wait_idle();
    regs = {reg_write_t'{CFG_IMAGE_WIDTH, 7'd2}, reg_write_t'{CFG_SHIFT_X, 7'd0},
            reg_write_t'{CFG_SHIFT_Y, 7'd7}};
    apply_regs(regs);
    pix = {8'd200, 8'd17};
    stream(pix);
    wait_idle();
    regs = {reg_write_t'{CFG_SHIFT_X, 7'h04}};
    apply_regs(regs);
    pix = {8'd99, 8'd255};
    stream(pix);

    // Width rewritten after one word: the scan restarts at the top-left.
    wait_idle();
    regs = {reg_write_t'{CFG_IMAGE_WIDTH, 7'd2}};
    apply_regs(regs);
    pix = {8'd1};
    stream(pix);
    wait_idle();
    apply_regs(regs);
    pix = {8'd0, 8'd255, 8'd170, 8'd85};
    stream(pix);

    // Random phases. The first two use an oversized width and the largest
    // one; after that widths stay mostly small so that whole images pass.
    w_eff = 2;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      regs.delete();
      if (phase < 2 || $urandom_range(0, 9) < 6) begin
        r = $urandom_range(0, 99);
        if (phase == 0)   wr = 7'd127;
        else if (phase == 1) wr = 7'd64;
        else if (r < 70)  wr = CFG_DATA_W'($urandom_range(1, 6));
        else if (r < 88)  wr = CFG_DATA_W'($urandom_range(7, 16));
        else if (r < 93)  wr = 7'd0;
        else if (r < 96)  wr = 7'd64;
        else              wr = CFG_DATA_W'($urandom_range(65, 127));
        regs.push_back(reg_write_t'{CFG_IMAGE_WIDTH, wr});
        w_eff = (wr == 0) ? 1 : ((int'(wr) > MAX_WIDTH) ? MAX_WIDTH : wr);
      end
      if ($urandom_range(0, 9) < 6) begin
        regs.push_back(reg_write_t'{CFG_SHIFT_X,
                                    {4'($urandom_range(0, 15)), 3'($urandom_range(0, 7))}});
      end
      if ($urandom_range(0, 9) < 6) begin
        regs.push_back(reg_write_t'{CFG_SHIFT_Y,
                                    {4'($urandom_range(0, 15)), 3'($urandom_range(0, 7))}});
      end
      if ($urandom_range(0, 19) == 0) begin
        regs.push_back(reg_write_t'{CFG_SPARE, CFG_DATA_W'($urandom_range(0, 127))});
      end
      apply_regs(regs);

      // Small images: one or two whole images, sometimes a partial one on top.
      // Large ones: two to three rows plus up to ten words, enough to read back the line buffer.
      area = w_eff * w_eff;
      if (area <= 121) begin
        n = area * $urandom_range(1, 2);
        if ($urandom_range(0, 1) == 1) n += $urandom_range(0, area - 1);
      end else begin
        n = $urandom_range(2 * w_eff, 3 * w_eff + 10);
      end

      // One phase runs into a long result-side hold-off with no input gaps,
      // so the block fills and must stall its input.
      if (phase == 4) begin
        if (n < 80) n = 80;
        src_gaps_on = 1'b0;
        hold_req    = 1'b1;
      end else begin
        src_gaps_on = ($urandom_range(0, 3) != 0);
      end

      pix.delete();
      repeat (n) begin
        r = $urandom_range(0, 9);
        pix.push_back((r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255)));
      end
      stream(pix);
      sent += n;
      phase++;
    end

    // Drain, then give stray words a few cycles to show up.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pixel_book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
